// ----- hw/rtl/deq_pkg.sv -----
// Package for the double-ended queue: command and status codes, the
// input and result word types, and the classified operation passed
// from the front part to the back part. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

  localparam int unsigned DEQ_CMD_W   = 3;
  localparam int unsigned DEQ_WORD_W  = 32;
  localparam int unsigned DEQ_STAT_W  = 2;
  localparam int unsigned DEQ_COUNT_W = 5;

  // Depth of the operation queue between the front and back parts.
  localparam int unsigned DEQ_Q_DEPTH = 2;
  localparam int unsigned DEQ_Q_IDX_W = 1;

  localparam logic [DEQ_CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [DEQ_CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [DEQ_CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [DEQ_CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [DEQ_CMD_W-1:0] CMD_PEEK_FRONT = 3'd4;
  localparam logic [DEQ_CMD_W-1:0] CMD_PEEK_BACK  = 3'd5;

  localparam logic [DEQ_STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [DEQ_STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [DEQ_STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [DEQ_CMD_W-1:0]  command;
    logic [DEQ_WORD_W-1:0] data_in;
  } deq_in_t;

  typedef struct packed {
    logic [DEQ_WORD_W-1:0]  data_out;
    logic [DEQ_STAT_W-1:0]  status;
    logic [DEQ_COUNT_W-1:0] count;
  } deq_out_t;

  // Classified operation. Neither is_push nor is_read means the command
  // is ignored and only reports the count.
  typedef struct packed {
    logic                  is_push;
    logic                  is_read;
    logic                  removes;
    logic                  at_back;
    logic [DEQ_WORD_W-1:0] word;
  } deq_op_t;

endpackage

`default_nettype wire

// ----- hw/rtl/deq_front.sv -----
// Front part of the double-ended queue: accepts command words, decodes
// them into operations and holds them in a two-entry queue.
// Depends on deq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module deq_front (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  output logic              busy,
  input  deq_pkg::deq_in_t  in_item,
  output logic              op_valid,
  output deq_pkg::deq_op_t  op,
  input  wire               op_take
);
  import deq_pkg::*;

  deq_op_t                slot_r [DEQ_Q_DEPTH];
  logic [DEQ_Q_IDX_W-1:0] wr_idx_r, wr_idx_nxt;
  logic [DEQ_Q_IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [DEQ_Q_IDX_W:0]   fill_r, fill_nxt;
  logic                   accept;
  logic                   take;
  deq_op_t                dec;

  always_comb begin
    dec         = '0;
    dec.word    = in_item.data_in;
    unique case (in_item.command)
      CMD_PUSH_FRONT: dec.is_push = 1'b1;
      CMD_PUSH_BACK: begin
        dec.is_push = 1'b1;
        dec.at_back = 1'b1;
      end
      CMD_POP_FRONT: begin
        dec.is_read = 1'b1;
        dec.removes = 1'b1;
      end
      CMD_POP_BACK: begin
        dec.is_read = 1'b1;
        dec.removes = 1'b1;
        dec.at_back = 1'b1;
      end
      CMD_PEEK_FRONT: dec.is_read = 1'b1;
      CMD_PEEK_BACK: begin
        dec.is_read = 1'b1;
        dec.at_back = 1'b1;
      end
      default: ;
    endcase
  end

  assign busy     = (fill_r == (DEQ_Q_IDX_W + 1)'(DEQ_Q_DEPTH));
  assign accept   = start && !busy;
  assign op_valid = (fill_r != '0);
  assign op       = slot_r[rd_idx_r];
  assign take     = op_valid && op_take;

  always_comb begin
    wr_idx_nxt = accept ? wr_idx_r + 1'b1 : wr_idx_r;
    rd_idx_nxt = take ? rd_idx_r + 1'b1 : rd_idx_r;
    fill_nxt   = fill_r;
    if (accept && !take) begin
      fill_nxt = fill_r + 1'b1;
    end else if (take && !accept) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot_r[wr_idx_r] <= dec;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/deq_back.sv -----
// Back part of the double-ended queue: the ring store, both end pointers
// and the count. Executes one operation per cycle and registers the result.
// Depends on deq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module deq_back #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               op_valid,
  input  deq_pkg::deq_op_t  op,
  output logic              op_take,
  output logic              out_valid,
  output deq_pkg::deq_out_t out_item
);
  import deq_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_r;
  logic [PTR_W-1:0]      front_r, front_nxt;
  logic [PTR_W-1:0]      back_r, back_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  out_valid_r;
  logic                  has_data_r;
  logic [DEQ_STAT_W-1:0] status_r, status;
  logic [CNT_W-1:0]      cnt_out_r;
  logic                  wr_en, rd_en;
  logic [PTR_W-1:0]      addr;
  logic [PTR_W-1:0]      front_prev, front_next, back_prev, back_next;
  logic                  full, empty;
  logic [DATA_WIDTH-1:0] word;
  logic [63:0]           rd_wide;

  // The back part never stalls, so every queued operation runs at once.
  assign op_take = op_valid;

  assign front_prev = (front_r == '0) ? LAST : front_r - 1'b1;
  assign front_next = (front_r == LAST) ? '0 : front_r + 1'b1;
  assign back_prev  = (back_r == '0) ? LAST : back_r - 1'b1;
  assign back_next  = (back_r == LAST) ? '0 : back_r + 1'b1;
  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign empty      = (cnt_r == '0);
  assign word       = DATA_WIDTH'(op.word);

  always_comb begin
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    addr      = front_r;
    front_nxt = front_r;
    back_nxt  = back_r;
    cnt_nxt   = cnt_r;
    status    = ST_OK;
    if (op.is_push) begin
      if (full) begin
        status = ST_FULL;
      end else begin
        wr_en   = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (op.at_back) begin
          addr     = back_r;
          back_nxt = back_next;
        end else begin
          addr      = front_prev;
          front_nxt = front_prev;
        end
      end
    end else if (op.is_read) begin
      if (empty) begin
        status = ST_EMPTY;
      end else begin
        rd_en = 1'b1;
        if (op.at_back) begin
          addr = back_prev;
          if (op.removes) begin
            back_nxt = back_prev;
            cnt_nxt  = cnt_r - 1'b1;
          end
        end else begin
          addr = front_r;
          if (op.removes) begin
            front_nxt = front_next;
            cnt_nxt   = cnt_r - 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      back_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= op_valid;
      if (op_valid) begin
        front_r <= front_nxt;
        back_r  <= back_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op_valid) begin
      has_data_r <= rd_en;
      status_r   <= status;
      cnt_out_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (op_valid && wr_en) begin
      mem[addr] <= word;
    end
    if (op_valid && rd_en) begin
      rd_r <= mem[addr];
    end
  end

  assign rd_wide           = 64'(rd_r);
  assign out_valid         = out_valid_r;
  assign out_item.data_out = has_data_r ? rd_wide[DEQ_WORD_W-1:0] : '0;
  assign out_item.status   = status_r;
  assign out_item.count    = DEQ_COUNT_W'(cnt_out_r);

endmodule

`default_nettype wire

// ----- hw/rtl/double_ended_queue.sv -----
// Top level of the double-ended queue: front decode and queue, back
// execution with the ring store, and interface assertions.
// Depends on deq_pkg, deq_front and deq_back.
//
//   Channel   Ports                        Transfer
//   input     start, busy, in_item         start high and busy low at a rising edge
//   result    out_valid, out_item          out_valid high for one cycle, always taken
//
// Each word is decoded into the front queue at acceptance, executed by the
// back part on the next edge, and its result is held in the back part's
// output registers. One word per cycle is sustained; the back part runs one
// operation per cycle on the store's single read/write port.
// Reset (rst_n low, synchronous) empties the queue and clears both pointers
// and the count. The receiver cannot stall; busy rises only if the front
// queue fills.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  output logic              busy,
  input  deq_pkg::deq_in_t  in_item,
  output logic              out_valid,
  output deq_pkg::deq_out_t out_item
);
  import deq_pkg::*;

  logic    op_valid;
  logic    op_take;
  deq_op_t op;

  deq_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .op_valid (op_valid),
    .op       (op),
    .op_take  (op_take)
  );

  deq_back #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (op_valid),
    .op        (op),
    .op_take   (op_take),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // Every accepted word gives its result on out_valid.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("accepted word produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##2 !out_valid)
    else $error("result without an accepted word");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == ST_FULL) |->
      (out_item.count == DEQ_COUNT_W'(DEPTH) && out_item.data_out == '0))
    else $error("full status with wrong count or data");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == ST_EMPTY) |->
      (out_item.count == '0 && out_item.data_out == '0))
    else $error("empty status with wrong count or data");

endmodule

`default_nettype wire

// ----- bench/double_ended_queue_tb.sv -----
// Self-checking testbench for the double-ended queue: directed and random
// command words, predicted by an in-bench model of the ring store.
// Depends on deq_pkg and double_ended_queue.
`timescale 1ns / 1ps

module double_ended_queue_tb;
  import deq_pkg::*;

  localparam int unsigned RING_DEPTH   = 16;
  localparam int unsigned PTR_W        = $clog2(RING_DEPTH);
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_GAP      = 40;
  localparam int unsigned MAX_REPORTS  = 40;

  // Command codes that the block ignores.
  localparam logic [DEQ_CMD_W-1:0] CMD_RSVD_6 = 3'd6;
  localparam logic [DEQ_CMD_W-1:0] CMD_RSVD_7 = 3'd7;

  logic     clk     = 1'b0;
  logic     rst_n   = 1'b0;
  logic     start   = 1'b0;
  deq_in_t  in_item = '0;
  logic     busy;
  logic     out_valid;
  deq_out_t out_item;

  int unsigned idle_pct    = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  // Model of the ring store and its pointers.
  logic [DEQ_WORD_W-1:0]  model_words [RING_DEPTH];
  logic [PTR_W-1:0]       model_front = '0;
  logic [PTR_W-1:0]       model_back  = '0;
  logic [DEQ_COUNT_W-1:0] model_count = '0;

  deq_out_t expected_results [$];

  always #5 clk = ~clk;

  double_ended_queue #(
    .DEPTH      (RING_DEPTH),
    .DATA_WIDTH (DEQ_WORD_W)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  function automatic deq_out_t apply_command(input deq_in_t w);
    deq_out_t r;
    r = '0;
    case (w.command)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (model_count == RING_DEPTH) begin
          r.status = ST_FULL;
        end else if (w.command == CMD_PUSH_FRONT) begin
          model_front              = model_front - 1'b1;
          model_words[model_front] = w.data_in;
          model_count              = model_count + 1'b1;
        end else begin
          model_words[model_back] = w.data_in;
          model_back              = model_back + 1'b1;
          model_count             = model_count + 1'b1;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK, CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
        if (model_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          case (w.command)
            CMD_POP_FRONT: begin
              r.data_out  = model_words[model_front];
              model_front = model_front + 1'b1;
              model_count = model_count - 1'b1;
            end
            CMD_POP_BACK: begin
              model_back  = model_back - 1'b1;
              r.data_out  = model_words[model_back];
              model_count = model_count - 1'b1;
            end
            CMD_PEEK_FRONT: r.data_out = model_words[model_front];
            default:        r.data_out = model_words[model_back - 1'b1];
          endcase
        end
      end
      default: ;
    endcase
    r.count = model_count;
    return r;
  endfunction

  task automatic note_mismatch(input string field, input logic [DEQ_WORD_W-1:0] want,
                               input logic [DEQ_WORD_W-1:0] got);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
  endtask

  // Checks each result word against the oldest prediction, then predicts the
  // word accepted at this edge. Both sample values from before the edge.
  always @(posedge clk) begin : result_monitor
    deq_out_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("double_ended_queue_tb: done, errors");
      $finish;
    end else if (rst_n) begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: unexpected result word, expected none actual %h",
                     $time, out_item);
        end else begin
          want = expected_results.pop_front();
          if (out_item.data_out !== want.data_out)
            note_mismatch("data_out", want.data_out, out_item.data_out);
          if (out_item.status !== want.status)
            note_mismatch("status", DEQ_WORD_W'(want.status), DEQ_WORD_W'(out_item.status));
          if (out_item.count !== want.count)
            note_mismatch("count", DEQ_WORD_W'(want.count), DEQ_WORD_W'(out_item.count));
        end
      end
      if (start && !busy)
        expected_results.push_back(apply_command(in_item));
    end
  end

  // Presents one word after a random idle gap and holds it until taken.
  // Start stays high afterwards so back-to-back words need no extra edge.
  task automatic send_word(input logic [DEQ_CMD_W-1:0] cmd,
                           input logic [DEQ_WORD_W-1:0] data);
    int unsigned gap;
    deq_in_t     w;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
      gap++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    w.command = cmd;
    w.data_in = data;
    start   <= 1'b1;
    in_item <= w;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic [DEQ_WORD_W-1:0] rand_data();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return DEQ_WORD_W'(1) << $urandom_range(DEQ_WORD_W - 1);
      3:       return ~(DEQ_WORD_W'(1) << $urandom_range(DEQ_WORD_W - 1));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DEQ_CMD_W-1:0] pick_command(input int unsigned push_pct);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 3)
      return $urandom_range(1) ? CMD_RSVD_6 : CMD_RSVD_7;
    if ($urandom_range(99) < push_pct)
      return $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
    case ($urandom_range(3))
      0:       return CMD_POP_FRONT;
      1:       return CMD_POP_BACK;
      2:       return CMD_PEEK_FRONT;
      default: return CMD_PEEK_BACK;
    endcase
  endfunction

  task automatic test_empty_reads();
    send_word(CMD_POP_FRONT, '1);
    send_word(CMD_POP_BACK, '0);
    send_word(CMD_PEEK_FRONT, 32'h8000_0001);
    send_word(CMD_PEEK_BACK, 32'h7FFF_FFFE);
  endtask

  task automatic test_reserved_commands();
    send_word(CMD_RSVD_6, '1);
    send_word(CMD_RSVD_7, 32'h5555_AAAA);
  endtask

  // Fills the store from both ends, then pushes into the full store and
  // reads both ends while full.
  task automatic test_fill_to_full();
    logic [DEQ_WORD_W-1:0] fixed [6];
    fixed = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001,
              32'h5555_5555, 32'hAAAA_AAAA};
    for (int i = 0; i < RING_DEPTH; i++)
      send_word((i % 2 == 0) ? CMD_PUSH_FRONT : CMD_PUSH_BACK,
                (i < 6) ? fixed[i] : rand_data());
    send_word(CMD_PUSH_FRONT, '1);
    send_word(CMD_PUSH_BACK, '1);
    send_word(CMD_PEEK_FRONT, '0);
    send_word(CMD_PEEK_BACK, '0);
  endtask

  // Runs of push-heavy, balanced and pop-heavy traffic so that the count
  // swings between empty and full and both pointers wrap often.
  task automatic test_random_traffic(input int unsigned pct, input int unsigned n_words);
    int unsigned           sent;
    int unsigned           bias;
    int unsigned           run_len;
    logic [DEQ_CMD_W-1:0]  cmd;
    idle_pct = pct;
    sent     = 0;
    while (sent < n_words) begin
      case ($urandom_range(2))
        0:       bias = 15;
        1:       bias = 50;
        default: bias = 85;
      endcase
      run_len = $urandom_range(40, 12);
      for (int i = 0; i < run_len && sent < n_words; i++) begin
        cmd = pick_command(bias);
        send_word(cmd, rand_data());
        if (cmd != CMD_RSVD_6 && cmd != CMD_RSVD_7)
          sent++;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_reads();
    test_reserved_commands();
    test_fill_to_full();
    test_random_traffic(0, 400);
    test_random_traffic(72, 375);
    test_random_traffic(15, 375);

    start <= 1'b0;
    while (expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0)
      $display("double_ended_queue_tb: done, clean");
    else
      $display("double_ended_queue_tb: done, errors");
    $finish;
  end

endmodule
